>>> sv/rpsa_pkg.sv
package rpsa_pkg;

    // slot table geometry
    localparam int FORE_SLOTS  = 32;
    localparam int BACK_SLOTS  = 32;
    localparam int TOTAL_SLOTS = FORE_SLOTS + BACK_SLOTS;
    localparam int SLOT_W      = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
    localparam int CNT_W       = $clog2(TOTAL_SLOTS + 1);

    // fixed field widths
    localparam int REQ_W   = 3;
    localparam int ID_W    = 32;
    localparam int IDX_W   = 6;
    localparam int TICK_W  = 32;
    localparam int USES_W  = 16;
    localparam int STAT_W  = 3;

    localparam logic [USES_W-1:0] USES_MAX = {USES_W{1'b1}};

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_GET_FORE = 3'd0,
        REQ_GET_BACK = 3'd1,
        REQ_FREE     = 3'd2,
        REQ_UNGET    = 3'd3,
        REQ_BLOW     = 3'd4,
        REQ_CLEAR    = 3'd5
    } req_code_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_EXISTING = 3'd0,
        ST_NEW      = 3'd1,
        ST_FULL     = 3'd2,
        ST_BAD_SLOT = 3'd3,
        ST_NOT_USED = 3'd4
    } status_t;

    // one table entry
    typedef struct packed {
        logic [ID_W-1:0]   owner;
        logic [USES_W-1:0] uses;
        logic [TICK_W-1:0] tick;
    } entry_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SCAN,
        S_READ,
        S_EVAL,
        S_DONE
    } state_t;

endpackage

>>> sv/rpsa_if.sv
interface rpsa_req_if;
    import rpsa_pkg::*;

    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [ID_W-1:0]     owner_id;
    logic [IDX_W-1:0]    slot_index;
    logic [TICK_W-1:0]   current_tick;

    modport source (output valid, output req_type, output owner_id, output slot_index,
                    output current_tick, input ready);
    modport sink   (input valid, input req_type, input owner_id, input slot_index,
                    input current_tick, output ready);
endinterface

interface rpsa_res_if;
    import rpsa_pkg::*;

    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    granted_slot;
    logic                needs_load;
    logic [STAT_W-1:0]   status;

    modport source (output valid, output granted_slot, output needs_load, output status,
                    input ready);
    modport sink   (input valid, input granted_slot, input needs_load, input status,
                    output ready);
endinterface

>>> sv/refcounted_palette_slot_allocator.sv
// Palette slot allocator with use counts and id sharing.
// Requests arrive on the req channel (valid/ready), one result per request
// leaves on the res channel through an output register.
// The table lives in a single-port memory read one slot per cycle; a small
// sequencer walks it, so the scan loop over the memory port sets the rate.
// A get searches all 32+32 slots for the id, then on a miss the back range
// (get back only) and then the fore range for an idle slot, and ends in the
// done state. Blow searches all slots for the id. Free and unget read the
// slot, decide and end in the done state; clear, a bad slot and unused
// codes go straight to the done state.
// The block takes no new request while one is in work; req.ready is high
// only in idle. A finished result waits in the output register while the
// receiver stalls, and the next request may already be accepted then; it
// is held at its end until the register is free.
// Reset clears per-slot valid bits at once, so every slot reads as empty
// right after reset; a clear request does the same when it is accepted.
module refcounted_palette_slot_allocator (
    input  logic       clk,
    input  logic       rst_n,
    rpsa_req_if.sink   req,
    rpsa_res_if.source res
);
    import rpsa_pkg::*;

    state_t              state_reg, state_next;

    // latched request
    req_code_t           req_code_reg;
    logic [ID_W-1:0]     id_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [TICK_W-1:0]   tick_reg;

    // scan control
    cnt_t                scan_reg, scan_next;
    cnt_t                end_reg, end_next;
    logic                pend_reg, pend_next;
    slot_t               cmp_idx_reg, cmp_idx_next;
    logic                back_pass_reg, back_pass_next;

    // pending result
    logic [IDX_W-1:0]    res_slot_reg, res_slot_next;
    logic                res_load_reg, res_load_next;
    status_t             res_status_reg, res_status_next;

    // output register
    logic                out_valid_reg;
    logic [IDX_W-1:0]    out_slot_reg;
    logic                out_load_reg;
    status_t             out_status_reg;

    // table memory and valid bits
    entry_t              mem [TOTAL_SLOTS];
    logic [TOTAL_SLOTS-1:0] valid_reg;
    entry_t              rd_data_reg;
    logic                rd_valid_reg;
    logic                rd_en;
    slot_t               rd_addr;
    logic                wr_en;
    slot_t               wr_addr;
    entry_t              wr_data;
    logic                clr_all;

    logic                accept;
    logic                issue;
    logic                hit;
    logic                scan_over;
    logic                bad_idx;
    logic                is_get;
    entry_t              ent;
    req_code_t           in_code;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign in_code   = req_code_t'(req.req_type);
    assign bad_idx   = 32'(req.slot_index) >= 32'(TOTAL_SLOTS);
    assign is_get    = (req_code_reg == REQ_GET_FORE) || (req_code_reg == REQ_GET_BACK);

    // entry seen by the sequencer; a never written slot reads as zero
    assign ent       = rd_valid_reg ? rd_data_reg : '0;
    assign issue     = scan_reg < end_reg;
    assign scan_over = !issue && !pend_reg;

    // compare of the entry read in the previous cycle
    always_comb
    begin
        hit = 1'b0;
        if (pend_reg)
        begin
            if (state_reg == S_FIND)
                hit = (ent.owner == id_reg);
            else if (state_reg == S_SCAN)
                hit = (ent.uses == '0) && ((ent.tick == '0) || (ent.tick != tick_reg));
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_code)
                        REQ_GET_FORE, REQ_GET_BACK, REQ_BLOW: state_next = S_FIND;
                        REQ_FREE, REQ_UNGET: state_next = bad_idx ? S_DONE : S_READ;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_FIND:
            begin
                if (hit)
                    state_next = S_DONE;
                else if (scan_over)
                    state_next = is_get ? S_SCAN : S_DONE;
            end
            S_SCAN:
            begin
                if (hit)
                    state_next = S_DONE;
                else if (scan_over && !back_pass_reg)
                    state_next = S_DONE;
            end
            S_READ:  state_next = S_EVAL;
            S_EVAL:  state_next = S_DONE;
            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        scan_next       = scan_reg;
        end_next        = end_reg;
        pend_next       = pend_reg;
        cmp_idx_next    = cmp_idx_reg;
        back_pass_next  = back_pass_reg;
        res_slot_next   = res_slot_reg;
        res_load_next   = res_load_reg;
        res_status_next = res_status_reg;
        rd_en           = 1'b0;
        rd_addr         = scan_reg[SLOT_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = cmp_idx_reg;
        wr_data         = ent;
        clr_all         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    scan_next       = '0;
                    end_next        = CNT_W'(TOTAL_SLOTS);
                    pend_next       = 1'b0;
                    back_pass_next  = 1'b0;
                    res_slot_next   = '0;
                    res_load_next   = 1'b0;
                    res_status_next = ST_EXISTING;
                    if ((in_code == REQ_FREE || in_code == REQ_UNGET) && bad_idx)
                        res_status_next = ST_BAD_SLOT;
                    if (in_code == REQ_CLEAR)
                        clr_all = 1'b1;
                end
            end
            S_FIND, S_SCAN:
            begin
                if (hit)
                begin
                    wr_en = 1'b1;
                    if (state_reg == S_SCAN)
                    begin
                        // claim an idle slot
                        wr_data.owner   = id_reg;
                        wr_data.uses    = USES_W'(1);
                        res_slot_next   = IDX_W'(cmp_idx_reg);
                        res_load_next   = 1'b1;
                        res_status_next = ST_NEW;
                    end
                    else if (is_get)
                    begin
                        // share the slot, saturating count
                        if (ent.uses != USES_MAX)
                            wr_data.uses = ent.uses + USES_W'(1);
                        res_slot_next = IDX_W'(cmp_idx_reg);
                    end
                    else
                    begin
                        // blow keeps the release tick
                        wr_data.owner = '0;
                        wr_data.uses  = '0;
                    end
                end
                else if (issue)
                begin
                    rd_en        = 1'b1;
                    scan_next    = scan_reg + CNT_W'(1);
                    pend_next    = 1'b1;
                    cmp_idx_next = scan_reg[SLOT_W-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (state_reg == S_FIND && is_get)
                        begin
                            if (req_code_reg == REQ_GET_BACK && BACK_SLOTS > 0)
                            begin
                                scan_next      = CNT_W'(FORE_SLOTS);
                                end_next       = CNT_W'(TOTAL_SLOTS);
                                back_pass_next = 1'b1;
                            end
                            else
                            begin
                                scan_next      = '0;
                                end_next       = CNT_W'(FORE_SLOTS);
                                back_pass_next = 1'b0;
                            end
                        end
                        else if (state_reg == S_SCAN && back_pass_reg)
                        begin
                            // back range full, fall back to fore
                            scan_next      = '0;
                            end_next       = CNT_W'(FORE_SLOTS);
                            back_pass_next = 1'b0;
                        end
                        else if (state_reg == S_SCAN)
                            res_status_next = ST_FULL;
                    end
                end
            end
            S_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = slot_t'(idx_reg);
            end
            S_EVAL:
            begin
                wr_addr = slot_t'(idx_reg);
                if (req_code_reg == REQ_FREE)
                begin
                    if (ent.uses == '0)
                        res_status_next = ST_NOT_USED;
                    else
                    begin
                        wr_en = 1'b1;
                        if (ent.uses == USES_W'(1))
                            wr_data.tick = tick_reg;
                        wr_data.uses = ent.uses - USES_W'(1);
                    end
                end
                else
                begin
                    wr_en = 1'b1;
                    if (ent.uses != '0)
                        wr_data.tick = tick_reg;
                    wr_data.uses = '0;
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_reg      <= '0;
            end_reg       <= '0;
            pend_reg      <= 1'b0;
            back_pass_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            end_reg       <= end_next;
            pend_reg      <= pend_next;
            back_pass_reg <= back_pass_next;
            if (clr_all)
                valid_reg <= '0;
            else if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (state_reg == S_DONE && (!out_valid_reg || res.ready))
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg    <= cmp_idx_next;
        res_slot_reg   <= res_slot_next;
        res_load_reg   <= res_load_next;
        res_status_reg <= res_status_next;
        if (accept)
        begin
            req_code_reg <= in_code;
            id_reg       <= req.owner_id;
            idx_reg      <= req.slot_index;
            tick_reg     <= req.current_tick;
        end
        if (state_reg == S_DONE && (!out_valid_reg || res.ready))
        begin
            out_slot_reg   <= res_slot_reg;
            out_load_reg   <= res_load_reg;
            out_status_reg <= res_status_reg;
        end
    end

    // table memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.granted_slot = out_slot_reg;
    assign res.needs_load   = out_load_reg;
    assign res.status       = out_status_reg;

    // table writes only come from a scan hit or a release decision
    a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_FIND || state_reg == S_SCAN || state_reg == S_EVAL))
        else $error("table write outside of a decision cycle");

    // an accepted request always leaves idle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("request accepted without starting work");

    // a load is flagged exactly for a new allocation
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.needs_load == (res.status == ST_NEW)))
        else $error("needs_load does not match status");

    // a result is loaded only at the end of a request
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (!$past(out_valid_reg) && out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result appeared without a finished request");

endmodule

>>> verif/tb_refcounted_palette_slot_allocator.sv
`timescale 1ns / 100ps

module tb_refcounted_palette_slot_allocator;
    import rpsa_pkg::*;

    // request codes the block decodes as no-ops
    localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 200;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int IDLE_PERCENT    = 21;
    localparam int ID_POOL_SIZE    = 48;
    localparam int LOG_DEPTH       = 16;

    typedef struct packed {
        logic [REQ_W-1:0]  code;
        logic [ID_W-1:0]   id;
        logic [IDX_W-1:0]  idx;
        logic [TICK_W-1:0] tick;
    } request_t;

    typedef struct packed {
        logic [IDX_W-1:0]  slot;
        logic              load;
        logic [STAT_W-1:0] status;
    } result_t;

    logic clk;
    logic rst_n;

    rpsa_req_if req_ch ();
    rpsa_res_if res_ch ();

    refcounted_palette_slot_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // mirror of the slot table
    logic [ID_W-1:0]   pal_owner [TOTAL_SLOTS];
    logic [USES_W-1:0] pal_uses  [TOTAL_SLOTS];
    logic [TICK_W-1:0] pal_rtick [TOTAL_SLOTS];

    result_t           pending_results [$];
    logic [IDX_W-1:0]  granted_log [$];
    logic [ID_W-1:0]   id_pool [ID_POOL_SIZE];
    logic [TICK_W-1:0] frame_tick;

    int   fail_count;
    int   quiet_cycles;
    int   hold_cycles;
    logic req_idle_en;
    logic res_idle_en;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endfunction

    function automatic void clear_table();
        for (int n = 0; n < TOTAL_SLOTS; n++)
        begin
            pal_owner[n] = '0;
            pal_uses[n]  = '0;
            pal_rtick[n] = '0;
        end
    endfunction

    // first slot holding the id, idle slots included
    function automatic int find_owner(input logic [ID_W-1:0] id);
        for (int n = 0; n < TOTAL_SLOTS; n++)
            if (pal_owner[n] == id)
                return n;
        return -1;
    endfunction

    // first idle slot in a range that was not released in this tick
    function automatic int find_claimable(input int first, input int count,
                                          input logic [TICK_W-1:0] tick);
        for (int n = first; n < first + count; n++)
            if (pal_uses[n] == '0 && (pal_rtick[n] == '0 || pal_rtick[n] != tick))
                return n;
        return -1;
    endfunction

    // expected result of one request, table mirror updated in place
    function automatic result_t predict_result(input request_t r);
        result_t res;
        int      hit;
        int      pick;
        res.slot   = '0;
        res.load   = 1'b0;
        res.status = ST_EXISTING;
        case (r.code)
            REQ_GET_FORE, REQ_GET_BACK:
            begin
                hit = find_owner(r.id);
                if (hit >= 0)
                begin
                    if (pal_uses[hit] != USES_MAX)
                        pal_uses[hit] = pal_uses[hit] + 1'b1;
                    res.slot = hit[IDX_W-1:0];
                end
                else
                begin
                    pick = -1;
                    if (r.code == REQ_GET_BACK)
                        pick = find_claimable(FORE_SLOTS, BACK_SLOTS, r.tick);
                    if (pick < 0)
                        pick = find_claimable(0, FORE_SLOTS, r.tick);
                    if (pick < 0)
                        res.status = ST_FULL;
                    else
                    begin
                        pal_owner[pick] = r.id;
                        pal_uses[pick]  = USES_W'(1);
                        res.slot        = pick[IDX_W-1:0];
                        res.load        = 1'b1;
                        res.status      = ST_NEW;
                    end
                end
            end
            REQ_FREE:
            begin
                if (int'(r.idx) >= TOTAL_SLOTS)
                    res.status = ST_BAD_SLOT;
                else if (pal_uses[r.idx] == '0)
                    res.status = ST_NOT_USED;
                else
                begin
                    if (pal_uses[r.idx] == 1)
                        pal_rtick[r.idx] = r.tick;
                    pal_uses[r.idx] = pal_uses[r.idx] - 1'b1;
                end
            end
            REQ_UNGET:
            begin
                if (int'(r.idx) >= TOTAL_SLOTS)
                    res.status = ST_BAD_SLOT;
                else
                begin
                    if (pal_uses[r.idx] != '0)
                        pal_rtick[r.idx] = r.tick;
                    pal_uses[r.idx] = '0;
                end
            end
            REQ_BLOW:
            begin
                hit = find_owner(r.id);
                if (hit >= 0)
                begin
                    pal_uses[hit]  = '0;
                    pal_owner[hit] = '0;
                end
            end
            REQ_CLEAR:
                clear_table();
            default:
                ;
        endcase
        return res;
    endfunction

    // one request transfer, expectation queued at acceptance
    task automatic issue_request(input logic [REQ_W-1:0] code, input logic [ID_W-1:0] id,
                                 input logic [IDX_W-1:0] idx, input logic [TICK_W-1:0] tick);
        request_t r;
        result_t  want;
        r.code = code;
        r.id   = id;
        r.idx  = idx;
        r.tick = tick;
        while (req_idle_en && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= r.code;
        req_ch.owner_id     <= r.id;
        req_ch.slot_index   <= r.idx;
        req_ch.current_tick <= r.tick;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        want = predict_result(r);
        pending_results.push_back(want);
        if ((r.code == REQ_GET_FORE || r.code == REQ_GET_BACK) && want.status != ST_FULL)
        begin
            granted_log.push_back(want.slot);
            if (granted_log.size() > LOG_DEPTH)
                void'(granted_log.pop_front());
        end
    endtask

    // mostly gets and releases of a small id set around a slowly moving tick
    function automatic request_t random_request();
        request_t r;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            frame_tick = frame_tick + $urandom_range(1, 3);
        else if (roll == 10)
            frame_tick = $urandom();

        roll = $urandom_range(0, 99);
        if (roll < 70)
            r.id = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
        else if (roll < 80)
            r.id = '0;
        else if (roll < 85)
            r.id = '1;
        else
            r.id = $urandom();

        roll = $urandom_range(0, 99);
        if (roll < 85)
            r.tick = frame_tick;
        else if (roll < 90)
            r.tick = '0;
        else if (roll < 95)
            r.tick = $urandom();
        else
            r.tick = frame_tick - 1;

        if (granted_log.size() != 0 && $urandom_range(0, 99) < 75)
            r.idx = granted_log[$urandom_range(0, granted_log.size() - 1)];
        else
            r.idx = IDX_W'($urandom_range(0, 63));

        roll = $urandom_range(0, 999);
        if (roll < 260)
            r.code = REQ_GET_FORE;
        else if (roll < 520)
            r.code = REQ_GET_BACK;
        else if (roll < 740)
            r.code = REQ_FREE;
        else if (roll < 850)
            r.code = REQ_UNGET;
        else if (roll < 960)
            r.code = REQ_BLOW;
        else if (roll < 965)
            r.code = REQ_CLEAR;
        else if (roll < 983)
            r.code = REQ_SPARE_A;
        else
            r.code = REQ_SPARE_B;
        return r;
    endfunction

    task automatic send_random(input int count);
        request_t r;
        for (int i = 0; i < count; i++)
        begin
            r = random_request();
            issue_request(r.code, r.id, r.idx, r.tick);
        end
    endtask

    // field extremes, sharing, reuse ban, blow, spare codes
    task automatic test_directed();
        issue_request(REQ_GET_FORE, 32'h0, 6'd0, 32'd1);
        issue_request(REQ_CLEAR, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
        issue_request(REQ_GET_FORE, 32'hFFFF_FFFF, 6'd0, 32'd0);
        issue_request(REQ_GET_BACK, 32'h0000_0001, 6'd0, 32'd5);
        issue_request(REQ_GET_FORE, 32'hFFFF_FFFF, 6'd0, 32'd5);
        issue_request(REQ_FREE, 32'h0, 6'd0, 32'd5);
        issue_request(REQ_FREE, 32'h0, 6'd0, 32'd5);
        issue_request(REQ_FREE, 32'h0, 6'd0, 32'd5);
        issue_request(REQ_GET_FORE, 32'h0000_0002, 6'd0, 32'd5);
        issue_request(REQ_GET_FORE, 32'hFFFF_FFFF, 6'd0, 32'd5);
        issue_request(REQ_UNGET, 32'h0, 6'd63, 32'd7);
        issue_request(REQ_UNGET, 32'h0, 6'd32, 32'hFFFF_FFFF);
        issue_request(REQ_GET_BACK, 32'h0000_0003, 6'd0, 32'hFFFF_FFFF);
        issue_request(REQ_BLOW, 32'h0000_0002, 6'd0, 32'd7);
        issue_request(REQ_BLOW, 32'h1234_5678, 6'd0, 32'd7);
        issue_request(REQ_BLOW, 32'h0, 6'd0, 32'd7);
        issue_request(REQ_SPARE_A, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
        issue_request(REQ_SPARE_B, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
        issue_request(REQ_FREE, 32'h0, 6'd33, 32'd0);
        issue_request(REQ_GET_BACK, 32'hA5A5_A5A5, 6'd0, 32'd0);
        issue_request(REQ_GET_BACK, 32'h5A5A_5A5A, 6'd0, 32'd0);
        issue_request(REQ_FREE, 32'hFFFF_FFFF, 6'd63, 32'd9);
        issue_request(REQ_UNGET, 32'h0, 6'd0, 32'd9);
        issue_request(REQ_GET_FORE, 32'h8000_0000, 6'd0, 32'd9);
    endtask

    // fill the back range, spill into fore, hit a full table, then release
    task automatic test_table_full();
        logic [TICK_W-1:0] t;
        t = 32'h0000_1000;
        issue_request(REQ_CLEAR, 32'h0, 6'd0, t);
        for (int i = 0; i < BACK_SLOTS; i++)
            issue_request(REQ_GET_BACK, 32'h100 + i, 6'd0, t);
        issue_request(REQ_GET_BACK, 32'h200, 6'd0, t);
        for (int i = 1; i < FORE_SLOTS; i++)
            issue_request(REQ_GET_FORE, 32'h200 + i, 6'd0, t);
        issue_request(REQ_GET_FORE, 32'h300, 6'd0, t);
        issue_request(REQ_GET_BACK, 32'h301, 6'd0, t);
        issue_request(REQ_FREE, 32'h0, 6'd5, t);
        issue_request(REQ_GET_FORE, 32'h302, 6'd0, t);
        issue_request(REQ_GET_FORE, 32'h302, 6'd0, t + 1);
        issue_request(REQ_UNGET, 32'h0, 6'd40, t + 1);
        issue_request(REQ_GET_BACK, 32'h303, 6'd0, t + 1);
        issue_request(REQ_GET_BACK, 32'h303, 6'd0, t + 2);
        issue_request(REQ_BLOW, 32'h110, 6'd0, t + 2);
        issue_request(REQ_GET_BACK, 32'h304, 6'd0, t + 2);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < ID_POOL_SIZE; i++)
            id_pool[i] = $urandom();
        frame_tick = $urandom();
        send_random(count);
    endtask

    // back-to-back stretch with both sides always ready
    task automatic test_steady_stream(input int count);
        req_idle_en = 1'b0;
        res_idle_en <= 1'b0;
        send_random(count);
        req_idle_en = 1'b1;
        res_idle_en <= 1'b1;
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        req_idle_en = 1'b0;
        hold_cycles <= HOLD_OFF_CYCLES;
        send_random(12);
        req_idle_en = 1'b1;
    endtask

    // hold-off countdown
    always @(posedge clk)
    begin
        if (hold_cycles != 0)
            hold_cycles <= hold_cycles - 1;
    end

    // result ready with random stalls
    always @(posedge clk)
    begin
        if (hold_cycles != 0)
            res_ch.ready <= 1'b0;
        else if (res_idle_en)
            res_ch.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        else
            res_ch.ready <= 1'b1;
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
                note_failure($sformatf("unexpected result: slot %0d load %0d status %0d",
                                       res_ch.granted_slot, res_ch.needs_load, res_ch.status));
            else
            begin
                want = pending_results.pop_front();
                if (res_ch.granted_slot !== want.slot || res_ch.needs_load !== want.load ||
                    res_ch.status !== want.status)
                    note_failure($sformatf(
                        "mismatch: slot exp %0d got %0d, load exp %0d got %0d, status exp %0d got %0d",
                        want.slot, res_ch.granted_slot, want.load, res_ch.needs_load,
                        want.status, res_ch.status));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = '0;
        req_ch.owner_id     = '0;
        req_ch.slot_index   = '0;
        req_ch.current_tick = '0;
        res_ch.ready        = 1'b0;
        fail_count          = 0;
        quiet_cycles        = 0;
        hold_cycles         = 0;
        req_idle_en         = 1'b1;
        res_idle_en         = 1'b1;
        frame_tick          = '0;
        clear_table();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_table_full();
        test_random(650);
        test_steady_stream(150);
        test_backpressure();
        test_random(650);

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
sv/rpsa_pkg.sv
sv/rpsa_if.sv
sv/refcounted_palette_slot_allocator.sv
verif/tb_refcounted_palette_slot_allocator.sv
